// ----- design/c3cb_pkg.sv -----
// shared types, constants and helpers for the 3x3 clamp-border convolution
package c3cb_pkg;

  localparam int OUT_W        = 35;
  localparam int COEF_W       = 16;
  localparam int COEF_ROW_W   = 3 * COEF_W;
  localparam int FW_W         = 11;
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 64;
  localparam int REG_IDX_W    = 2;
  localparam int REG_OFFSET_W = 3;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);
  localparam int PEND_W     = FIFO_CW + 1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_TOP    = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_MIDDLE = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_BOTTOM = 2'd3;

  localparam logic [FW_W-1:0]       FRAME_WIDTH_RST   = 11'd1024;
  localparam logic [COEF_ROW_W-1:0] COEFF_TOP_RST     = 48'h0;
  localparam logic [COEF_ROW_W-1:0] COEFF_MIDDLE_RST  = 48'h0000_0100_0000;
  localparam logic [COEF_ROW_W-1:0] COEFF_BOTTOM_RST  = 48'h0;

  typedef struct packed {
    logic [FW_W-1:0]                 frame_width;
    logic [2:0][COEF_ROW_W-1:0]      coeff;
  } c3cb_cfg_t;

  typedef struct packed {
    logic a_valid;
    logic a_last;
    logic a_eof;
    logic b_valid;
  } c3cb_flags_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] value;
    logic                    last;
    logic                    eof;
  } c3cb_result_t;

  function automatic logic [1:0] flag_count(c3cb_flags_t f);
    return {1'b0, f.a_valid} + {1'b0, f.b_valid};
  endfunction

endpackage

// ----- design/c3cb_cfg_regs.sv -----
// apb configuration registers: frame width and the three kernel rows
module c3cb_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [c3cb_pkg::PADDR_W-1:0]      paddr,
  input  logic [c3cb_pkg::PDATA_W-1:0]      pwdata,
  output logic [c3cb_pkg::PDATA_W-1:0]      prdata,
  output logic                              pready,
  output c3cb_pkg::c3cb_cfg_t               cfg
);
  import c3cb_pkg::*;

  logic                 wr;
  logic [REG_IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = paddr[PADDR_W-1:REG_OFFSET_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width <= FRAME_WIDTH_RST;
      cfg.coeff[0]    <= COEFF_TOP_RST;
      cfg.coeff[1]    <= COEFF_MIDDLE_RST;
      cfg.coeff[2]    <= COEFF_BOTTOM_RST;
    end else if (wr) begin
      case (idx)
        REG_FRAME_WIDTH:  cfg.frame_width <= pwdata[FW_W-1:0];
        REG_COEFF_TOP:    cfg.coeff[0]    <= pwdata[COEF_ROW_W-1:0];
        REG_COEFF_MIDDLE: cfg.coeff[1]    <= pwdata[COEF_ROW_W-1:0];
        REG_COEFF_BOTTOM: cfg.coeff[2]    <= pwdata[COEF_ROW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FRAME_WIDTH:  prdata = PDATA_W'(cfg.frame_width);
      REG_COEFF_TOP:    prdata = PDATA_W'(cfg.coeff[0]);
      REG_COEFF_MIDDLE: prdata = PDATA_W'(cfg.coeff[1]);
      REG_COEFF_BOTTOM: prdata = PDATA_W'(cfg.coeff[2]);
      default:          prdata = '0;
    endcase
  end

endmodule

// ----- design/c3cb_line_store.sv -----
// two-row line store, one write port and three registered read ports over two copies
module c3cb_line_store #(
  parameter int DEPTH = 1024,
  parameter int DW    = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr0,
  input  logic [AW-1:0] raddr1,
  input  logic [AW-1:0] raddr2,
  output logic [DW-1:0] rdata0,
  output logic [DW-1:0] rdata1,
  output logic [DW-1:0] rdata2
);

  logic [DW-1:0] mem_a [DEPTH];
  logic [DW-1:0] mem_b [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[waddr] <= wdata;
    end
    rdata0 <= mem_a[raddr0];
    rdata1 <= mem_a[raddr1];
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_b[waddr] <= wdata;
    end
    rdata2 <= mem_b[raddr2];
  end

endmodule

// ----- design/c3cb_mac.sv -----
// pipelined 3x3 multiply-accumulate: products, then row sums, then the final add
module c3cb_mac #(
  parameter int PIXEL_BITS = 16
) (
  input  logic                                    clk,
  input  logic [8:0][PIXEL_BITS-1:0]              taps,
  input  logic [2:0][c3cb_pkg::COEF_ROW_W-1:0]    coeff,
  output logic signed [c3cb_pkg::OUT_W-1:0]       sum
);
  import c3cb_pkg::*;

  localparam int PW = PIXEL_BITS + COEF_W;

  logic [8:0][PW-1:0]    prod;
  logic [2:0][OUT_W-1:0] row_sum;

  // tap index is 3*column + row
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      for (int r = 0; r < 3; r++) begin
        prod[3*k+r] <= PW'($signed(taps[3*k+r]) * $signed(coeff[r][COEF_W*k +: COEF_W]));
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] <= OUT_W'($signed(prod[r])) + OUT_W'($signed(prod[3+r]))
                  + OUT_W'($signed(prod[6+r]));
    end
  end

  assign sum = $signed(row_sum[0] + row_sum[1] + row_sum[2]);

endmodule

// ----- design/c3cb_result_fifo.sv -----
// result queue taking up to two beats per cycle and giving one while ready is high
module c3cb_result_fifo (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [1:0]                       push_cnt,
  input  c3cb_pkg::c3cb_result_t           push0,
  input  c3cb_pkg::c3cb_result_t           push1,
  output logic                             valid,
  input  logic                             ready,
  output c3cb_pkg::c3cb_result_t           head,
  output logic [c3cb_pkg::FIFO_CW-1:0]     count
);
  import c3cb_pkg::*;

  c3cb_result_t       mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] wptr_inc;
  logic [FIFO_AW-1:0] rptr;
  logic               pop;

  assign valid    = (count != '0);
  assign pop      = valid && ready;
  assign head     = mem[rptr];
  assign wptr_inc = wptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + FIFO_AW'(push_cnt);
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + FIFO_CW'(push_cnt) - FIFO_CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wptr] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wptr_inc] <= push1;
    end
  end

endmodule

// ----- design/conv3x3_clamp_border.sv -----
// top level of the streaming 3x3 convolution with clamped border
// a result beat passes stage 1, the product and row-sum registers and the result queue
// throughput: one item per cycle; the row-end item gives two beats, which share the
//   one-beat-per-cycle result port, so the 16-entry result queue sets when ready drops
// reset: synchronous, clears counters, window, pipeline and queue; line store is not cleared
module conv3x3_clamp_border #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                pixel_valid,
  output logic                                pixel_ready,
  input  logic                                opcode,
  input  logic signed [PIXEL_BITS-1:0]        pixel,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic signed [c3cb_pkg::OUT_W-1:0]   filtered_value,
  output logic                                last_of_run,
  output logic                                end_of_frame,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [c3cb_pkg::PADDR_W-1:0]        paddr,
  input  logic [c3cb_pkg::PDATA_W-1:0]        pwdata,
  output logic [c3cb_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);
  import c3cb_pkg::*;

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int PB = PIXEL_BITS;
  localparam int DW = 2 * PIXEL_BITS;

  typedef logic [2:0][PB-1:0] col_t;

  c3cb_cfg_t cfg;

  c3cb_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // effective last column
  logic [31:0]   fw_ext;
  logic [AW-1:0] last_col;

  always_comb begin
    fw_ext = 32'(cfg.frame_width);
    if (fw_ext == 32'd0) begin
      last_col = '0;
    end else if (fw_ext > 32'(MAX_WIDTH)) begin
      last_col = AW'(MAX_WIDTH - 1);
    end else begin
      last_col = AW'(fw_ext - 32'd1);
    end
  end

  // front-end state
  logic [AW-1:0] column_count, column_count_next;
  logic [1:0]    rows_seen, rows_seen_next;
  logic [AW-1:0] flush_column, flush_column_next;

  logic          accept;
  logic          is_pix;
  logic [1:0]    rs_eff;
  logic          pix_end;
  logic [AW-1:0] fcol;
  logic [AW-1:0] fl;
  logic [AW-1:0] fr;
  logic          fl_end;
  logic [AW-1:0] raddr0;
  logic          rs2_next;
  c3cb_flags_t   flags_next;

  assign accept = pixel_valid && pixel_ready;
  assign is_pix = (opcode == OP_PIXEL);

  always_comb begin
    rs_eff  = (flush_column != '0) ? 2'd0 : rows_seen;
    pix_end = (column_count >= last_col);
    fcol    = (flush_column > last_col) ? last_col : flush_column;
    fl      = (fcol != '0) ? fcol - 1'b1 : '0;
    fr      = (fcol < last_col) ? fcol + 1'b1 : fcol;
    fl_end  = (fcol >= last_col);
    raddr0  = is_pix ? column_count : fl;

    if (is_pix) begin
      rs2_next           = (rs_eff >= 2'd2);
      flags_next.a_valid = (rs_eff != 2'd0) && (column_count != '0);
      flags_next.a_last  = !pix_end;
      flags_next.a_eof   = 1'b0;
      flags_next.b_valid = (rs_eff != 2'd0) && pix_end;
    end else begin
      rs2_next           = (rows_seen >= 2'd2);
      flags_next.a_valid = (rows_seen != 2'd0);
      flags_next.a_last  = 1'b1;
      flags_next.a_eof   = fl_end;
      flags_next.b_valid = 1'b0;
    end

    column_count_next = column_count;
    rows_seen_next    = rows_seen;
    flush_column_next = flush_column;
    if (accept) begin
      if (is_pix) begin
        rows_seen_next    = rs_eff;
        flush_column_next = '0;
        if (pix_end) begin
          column_count_next = '0;
          if (rs_eff < 2'd2) begin
            rows_seen_next = rs_eff + 2'd1;
          end
        end else begin
          column_count_next = column_count + 1'b1;
        end
      end else begin
        column_count_next = '0;
        if (rows_seen != 2'd0) begin
          if (fl_end) begin
            flush_column_next = '0;
            rows_seen_next    = 2'd0;
          end else begin
            flush_column_next = fcol + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      rows_seen    <= 2'd0;
      flush_column <= '0;
    end else begin
      column_count <= column_count_next;
      rows_seen    <= rows_seen_next;
      flush_column <= flush_column_next;
    end
  end

  // stage 1 registers
  logic                 s1_valid;
  c3cb_flags_t          s1_flags, s2_flags, s3_flags;
  logic                 s1_is_pix;
  logic signed [PB-1:0] s1_pixel;
  logic [AW-1:0]        s1_addr0, s1_addr1, s1_addr2;
  logic                 s1_x_is1;
  logic                 s1_x_ge1;
  logic                 s1_rs2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_flags <= '0;
      s2_flags <= '0;
      s3_flags <= '0;
    end else begin
      s1_valid <= accept;
      s1_flags <= accept ? flags_next : '0;
      s2_flags <= s1_flags;
      s3_flags <= s2_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_is_pix <= is_pix;
      s1_pixel  <= pixel;
      s1_addr0  <= raddr0;
      s1_addr1  <= fcol;
      s1_addr2  <= fr;
      s1_x_is1  <= (column_count == AW'(1));
      s1_x_ge1  <= (column_count != '0);
      s1_rs2    <= rs2_next;
    end
  end

  // line store, entries hold {older, newer}
  logic          we;
  logic [DW-1:0] wdata;
  logic [DW-1:0] ram_rd0, ram_rd1, ram_rd2;

  c3cb_line_store #(
    .DEPTH (MAX_WIDTH),
    .DW    (DW)
  ) u_lines (
    .clk    (clk),
    .we     (we),
    .waddr  (s1_addr0),
    .wdata  (wdata),
    .raddr0 (raddr0),
    .raddr1 (fcol),
    .raddr2 (fr),
    .rdata0 (ram_rd0),
    .rdata1 (ram_rd1),
    .rdata2 (ram_rd2)
  );

  // forward the write made on the same edge as the read
  logic          bp_valid;
  logic [AW-1:0] bp_addr;
  logic [DW-1:0] bp_data;
  logic [DW-1:0] rd0, rd1, rd2;

  always_comb begin
    rd0 = (bp_valid && bp_addr == s1_addr0) ? bp_data : ram_rd0;
    rd1 = (bp_valid && bp_addr == s1_addr1) ? bp_data : ram_rd1;
    rd2 = (bp_valid && bp_addr == s1_addr2) ? bp_data : ram_rd2;
  end

  col_t lcol0, lcol1, lcol2;
  col_t ncol;
  col_t win0, win1, win2;
  col_t a_l, a_c, a_r;
  col_t b_l, b_c, b_r;

  always_comb begin
    lcol0[0] = s1_rs2 ? rd0[DW-1:PB] : rd0[PB-1:0];
    lcol0[1] = rd0[PB-1:0];
    lcol0[2] = rd0[PB-1:0];
    lcol1[0] = s1_rs2 ? rd1[DW-1:PB] : rd1[PB-1:0];
    lcol1[1] = rd1[PB-1:0];
    lcol1[2] = rd1[PB-1:0];
    lcol2[0] = s1_rs2 ? rd2[DW-1:PB] : rd2[PB-1:0];
    lcol2[1] = rd2[PB-1:0];
    lcol2[2] = rd2[PB-1:0];

    ncol    = lcol0;
    ncol[2] = s1_pixel;

    we    = s1_valid && s1_is_pix;
    wdata = {rd0[PB-1:0], s1_pixel};

    if (s1_is_pix) begin
      a_l = s1_x_is1 ? win2 : win1;
      a_c = win2;
      a_r = ncol;
    end else begin
      a_l = lcol0;
      a_c = lcol1;
      a_r = lcol2;
    end
    b_l = s1_x_ge1 ? win2 : ncol;
    b_c = ncol;
    b_r = ncol;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bp_valid <= 1'b0;
      win0     <= '0;
      win1     <= '0;
      win2     <= '0;
    end else if (we) begin
      bp_valid <= 1'b1;
      win0     <= win1;
      win1     <= win2;
      win2     <= ncol;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      bp_addr <= s1_addr0;
      bp_data <= wdata;
    end
  end

  // two multiply-accumulate units: first and second beat of an item
  logic signed [OUT_W-1:0] sum_a, sum_b;

  c3cb_mac #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mac_a (
    .clk   (clk),
    .taps  ({a_r, a_c, a_l}),
    .coeff (cfg.coeff),
    .sum   (sum_a)
  );

  c3cb_mac #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mac_b (
    .clk   (clk),
    .taps  ({b_r, b_c, b_l}),
    .coeff (cfg.coeff),
    .sum   (sum_b)
  );

  // result queue
  c3cb_result_t         e_a, e_b, push0, head;
  logic [1:0]           push_cnt;
  logic [FIFO_CW-1:0]   fifo_count;
  logic [PEND_W-1:0]    pending;

  always_comb begin
    e_a.value = sum_a;
    e_a.last  = s3_flags.a_last;
    e_a.eof   = s3_flags.a_eof;
    e_b.value = sum_b;
    e_b.last  = 1'b1;
    e_b.eof   = 1'b0;
    push0     = s3_flags.a_valid ? e_a : e_b;
    push_cnt  = flag_count(s3_flags);
  end

  c3cb_result_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push_cnt (push_cnt),
    .push0    (push0),
    .push1    (e_b),
    .valid    (result_valid),
    .ready    (result_ready),
    .head     (head),
    .count    (fifo_count)
  );

  // room for every beat in flight plus the worst case of a new item
  assign pending = PEND_W'(fifo_count) + PEND_W'(flag_count(s1_flags))
                 + PEND_W'(flag_count(s2_flags)) + PEND_W'(flag_count(s3_flags));
  assign pixel_ready = (pending <= PEND_W'(FIFO_DEPTH - 2));

  assign filtered_value = head.value;
  assign last_of_run    = head.last;
  assign end_of_frame   = head.eof;

endmodule
